// File: hw/rtl/oksp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package oksp_pkg;
	localparam int KeyBits = 32;
	localparam int PayBits = 32;
	localparam int Capacity = 256;
	localparam int SlotBits = $clog2(Capacity);
	localparam int CountBits = $clog2(Capacity + 1);

	typedef enum logic [1:0] {
		CMD_FIND    = 2'd0,
		CMD_CLOSEST = 2'd1,
		CMD_WRITE   = 2'd2,
		CMD_DELETE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// One memory write request from the sequencer to the store.
	typedef struct packed {
		logic                en;
		logic [SlotBits-1:0] addr;
		logic [KeyBits-1:0]  key;
		logic [PayBits-1:0]  pay;
	} mem_wr_t;
endpackage
`default_nettype wire

// File: hw/rtl/oksp_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Key and payload memory, one write port and one registered read port.
module oksp_store (
	input  wire                                 clk,
	input  wire  [oksp_pkg::SlotBits-1:0]       rd_addr,
	input  wire  oksp_pkg::mem_wr_t             wr,
	output logic [oksp_pkg::KeyBits-1:0]        rd_key,
	output logic [oksp_pkg::PayBits-1:0]        rd_pay
);
	logic [oksp_pkg::KeyBits-1:0] key_mem [oksp_pkg::Capacity];
	logic [oksp_pkg::PayBits-1:0] pay_mem [oksp_pkg::Capacity];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr.addr] <= wr.key;
			pay_mem[wr.addr] <= wr.pay;
		end
		rd_key <= key_mem[rd_addr];
		rd_pay <= pay_mem[rd_addr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/ordered_key_store_predecessor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | dir | fields (lowest bit first)
// s_axis  | in  | tdata: command[1:0] key[33:2] range_floor[65:34] payload[97:66]
//         |     |        write_flags[99:98], zero fill to 104 bits
// m_axis  | out | tdata: found[0] status[2:1] result_key[34:3]
//         |     |        result_payload[66:35] entry_count[75:67], zero fill to 80
//
// Each word is handled by a scan of every slot through the single read port
// of the store, one slot per cycle, and then passes through S_DONE and S_OUT.
// The next word is accepted once the result has been loaded into the output
// register, so a result still held by the sink stalls S_OUT and the next word.
// Reset clears the valid bits, the count and the control state; the memories
// themselves are never cleared, as a slot is only trusted while valid.
// A result waits in the output register while the next word is accepted; the
// next result is not written until the register has been taken.
module ordered_key_store_predecessor_core (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [103:0] s_axis_tdata,  // command, key, range_floor, payload, write_flags
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [79:0]  m_axis_tdata   // found, status, result_key, result_payload, entry_count
);
	localparam int SB = oksp_pkg::SlotBits;
	localparam int KB = oksp_pkg::KeyBits;
	localparam int PB = oksp_pkg::PayBits;
	localparam int CB = oksp_pkg::CountBits;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_DONE = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [oksp_pkg::Capacity-1:0] valid_q;
	logic [CB-1:0] count_q;
	logic [1:0]    cmd_q;
	logic [KB-1:0] key_q, floor_q;
	logic [PB-1:0] pay_q;
	logic [1:0]    flags_q;
	logic [SB:0]   addr_q;     // read address issued
	logic [SB-1:0] chk_s1;     // slot whose data arrives this cycle
	logic          chk_v_s1;
	logic          hit_q, free_v_q;
	logic [SB-1:0] hit_slot_q, free_q;
	logic [KB-1:0] hit_key_q;
	logic [PB-1:0] hit_pay_q;
	logic [KB-1:0] rd_key;
	logic [PB-1:0] rd_pay;
	oksp_pkg::mem_wr_t wr;
	logic          cand, better;

	logic [0:0]    r_found;
	logic [1:0]    r_status;
	logic [KB-1:0] r_key;
	logic [PB-1:0] r_pay;
	logic [CB-1:0] r_count;

	oksp_store u_store (
		.clk    (clk),
		.rd_addr(addr_q[SB-1:0]),
		.wr     (wr),
		.rd_key (rd_key),
		.rd_pay (rd_pay)
	);

	assign s_axis_tready = (state_q == S_IDLE);

	// A slot is a candidate if valid and it matches the command's test.
	always_comb begin
		cand = 1'b0;
		better = 1'b0;
		if (chk_v_s1 && valid_q[chk_s1]) begin
			if (cmd_q == oksp_pkg::CMD_CLOSEST) begin
				cand = (rd_key <= key_q);
				better = !hit_q || (rd_key > hit_key_q);
			end else begin
				cand = (rd_key == key_q);
				better = !hit_q;
			end
		end
	end

	// The write is decided at the end of the scan.
	always_comb begin
		wr = '0;
		wr.key = key_q;
		wr.pay = pay_q;
		if (state_q == S_DONE && cmd_q == oksp_pkg::CMD_WRITE) begin
			if (hit_q) begin
				wr.en = flags_q[1];
				wr.addr = hit_slot_q;
			end else begin
				wr.en = flags_q[0] && free_v_q;
				wr.addr = free_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			count_q <= '0;
			m_axis_tvalid <= 1'b0;
			chk_v_s1 <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q   <= s_axis_tdata[1:0];
						key_q   <= s_axis_tdata[2 +: KB];
						floor_q <= s_axis_tdata[34 +: KB];
						pay_q   <= s_axis_tdata[66 +: PB];
						flags_q <= s_axis_tdata[99:98];
						addr_q  <= '0;
						hit_q   <= 1'b0;
						free_v_q <= 1'b0;
						chk_v_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					chk_v_s1 <= !addr_q[SB];
					chk_s1 <= addr_q[SB-1:0];
					if (!addr_q[SB]) begin
						addr_q <= addr_q + 1'b1;
						if (!valid_q[addr_q[SB-1:0]] && !free_v_q) begin
							free_v_q <= 1'b1;
							free_q <= addr_q[SB-1:0];
						end
					end
					if (cand && better) begin
						hit_q <= 1'b1;
						hit_slot_q <= chk_s1;
						hit_key_q <= rd_key;
						hit_pay_q <= rd_pay;
					end
					if (addr_q[SB] && !chk_v_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					r_found <= 1'b0;
					r_status <= oksp_pkg::ST_FAIL;
					r_key <= '0;
					r_pay <= '0;
					r_count <= count_q;
					if (hit_q && !(cmd_q == oksp_pkg::CMD_CLOSEST && hit_key_q < floor_q)) begin
						r_found <= 1'b1;
						r_key <= hit_key_q;
						r_pay <= hit_pay_q;
					end
					case (cmd_q)
						oksp_pkg::CMD_FIND, oksp_pkg::CMD_CLOSEST: begin
							if (hit_q && !(cmd_q == oksp_pkg::CMD_CLOSEST
							    && hit_key_q < floor_q))
								r_status <= oksp_pkg::ST_OK;
						end
						oksp_pkg::CMD_WRITE: begin
							if (hit_q) begin
								if (flags_q[1]) r_status <= oksp_pkg::ST_OK;
							end else if (flags_q[0]) begin
								if (!free_v_q) begin
									r_status <= oksp_pkg::ST_FULL;
								end else begin
									r_status <= oksp_pkg::ST_OK;
									valid_q[free_q] <= 1'b1;
									count_q <= count_q + 1'b1;
									r_count <= count_q + 1'b1;
								end
							end
						end
						oksp_pkg::CMD_DELETE: begin
							if (hit_q) begin
								r_status <= oksp_pkg::ST_OK;
								valid_q[hit_slot_q] <= 1'b0;
								count_q <= count_q - 1'b1;
								r_count <= count_q - 1'b1;
							end
						end
						default: ;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output word: held in the result registers while tvalid is high, since a
	// new result is only copied in from S_OUT after the previous was taken.
	logic [CB-1:0] o_count_q;
	logic [0:0]    o_found_q;
	logic [1:0]    o_status_q;
	logic [KB-1:0] o_key_q;
	logic [PB-1:0] o_pay_q;
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
			o_found_q <= r_found;
			o_status_q <= r_status;
			o_key_q <= r_key;
			o_pay_q <= r_pay;
			o_count_q <= r_count;
		end
	end
	assign m_axis_tdata = {4'b0, o_count_q, o_pay_q, o_key_q, o_status_q, o_found_q};
endmodule
`default_nettype wire

// File: hw/rtl/oksp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module oksp_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [79:0]  m_axis_tdata
);
	// A stalled result holds its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// The block is busy in the cycle after accepting a word.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("word accepted back to back");
	// A found result never reports store full.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] != 2'd2)
		else $error("found with store full");
	// A miss carries a zero key.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[34:3] == 32'd0)
		else $error("miss with nonzero key");
endmodule

bind ordered_key_store_predecessor_core oksp_checker u_chk (.*);
`default_nettype wire
